// ===== rtl/core/unicyc_pkg.sv =====
// Shared constants and the sine table builder for the unicycle pose integrator.
package unicyc_pkg;

    // Reset value of the integration step (Q0.16 seconds, about 10 ms)
    localparam logic [15:0] STEP_TIME_RESET = 16'd655;

    // Default address width of the quarter-wave sine table
    localparam int SINE_TABLE_BITS_DEF = 8;

    // Taylor coefficients of sin(pi/2 * t), Q30, lowest order first
    localparam longint POLY_C1  = 64'sd1686629713;
    localparam longint POLY_C3  = -64'sd693598669;
    localparam longint POLY_C5  = 64'sd85569307;
    localparam longint POLY_C7  = -64'sd5026995;
    localparam longint POLY_C9  = 64'sd172272;
    localparam longint POLY_C11 = -64'sd3864;

    // a * b / 2^30, truncated toward zero (b is never negative)
    function automatic longint mul_q30(input longint a, input longint b);
        longint r;
        if (a < 0) begin
            r = -(((-a) * b) >>> 30);
        end else begin
            r = (a * b) >>> 30;
        end
        return r;
    endfunction

    // Quarter-wave table entry k in Q1.15 (0..32768); elaboration time only
    function automatic logic [15:0] sine_entry(input int k, input int bits);
        longint t;
        longint t2;
        longint acc;
        longint s;
        t   = (longint'(k) <<< 30) >>> bits;
        t2  = mul_q30(t, t);
        acc = POLY_C11;
        acc = POLY_C9 + mul_q30(acc, t2);
        acc = POLY_C7 + mul_q30(acc, t2);
        acc = POLY_C5 + mul_q30(acc, t2);
        acc = POLY_C3 + mul_q30(acc, t2);
        acc = POLY_C1 + mul_q30(acc, t2);
        s   = mul_q30(acc, t);
        if (s < 0) begin
            s = 0;
        end
        s = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32768) begin
            s = 64'sd32768;
        end
        return 16'(s);
    endfunction

endpackage

// ===== rtl/core/unicycle_pose_euler_step.sv =====
// Top level: unicycle pose integrator, one Euler step per request.
//
// Each input request (speed, turn_rate) advances the stored pose by one
// explicit Euler step: x += speed*sin(h)*dt, y += speed*cos(h)*dt with the
// old heading h, then h += turn_rate*dt modulo one turn. Positions are
// Q16.16 and saturate; the updated pose is sent out as one result request.
// One signed 32x17 multiplier is shared by all four products under a small
// sequencer (S_SPD, S_RATE, S_HEAD, S_RNDX, S_ADDX, S_RNDY, S_ADDY, S_OUT);
// a new request is taken only once the last has loaded the result register,
// and S_OUT waits while that register is held by an untaken result; s_tready
// is high only between requests. The result register lets the next request
// start while the previous result waits. The pose resets to the origin,
// step_time to 655; step_time is written through the cfg channel, which is
// always ready, by the user only while idle; the block does not enforce it.
module unicycle_pose_euler_step #(
    parameter int SINE_TABLE_BITS = unicyc_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [15:0] speed, [39:16] turn_rate
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
    output logic        m_tuser,    // [0] saturated
    // step_time register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int QUARTER = 1 << SINE_TABLE_BITS;
    localparam int IDX_W   = SINE_TABLE_BITS + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SPD  = 4'd1;
    localparam logic [3:0] S_RATE = 4'd2;
    localparam logic [3:0] S_HEAD = 4'd3;
    localparam logic [3:0] S_RNDX = 4'd4;
    localparam logic [3:0] S_ADDX = 4'd5;
    localparam logic [3:0] S_RNDY = 4'd6;
    localparam logic [3:0] S_ADDY = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // control and state registers
    logic [3:0]         state_reg, state_next;
    logic [15:0]        step_time_reg, step_time_next;
    logic signed [31:0] pose_x_reg, pose_x_next;
    logic signed [31:0] pose_y_reg, pose_y_next;
    logic [15:0]        pose_heading_reg, pose_heading_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic signed [15:0] speed_reg, speed_next;
    logic signed [23:0] rate_reg, rate_next;
    logic signed [48:0] prod_reg, prod_next;
    logic signed [31:0] pv_reg, pv_next;
    logic signed [16:0] sin_reg, sin_next;
    logic signed [16:0] cos_reg, cos_next;
    logic signed [25:0] delta_reg, delta_next;
    logic               clip_reg, clip_next;
    logic [79:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    // quarter-wave sine table, built at elaboration
    logic [15:0] sine_rom [0:QUARTER];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        assign sine_rom[k] = unicyc_pkg::sine_entry(k, SINE_TABLE_BITS);
    end

    // table lookup: quadrant mirror and sign
    logic [15:0]                angle_sel;
    logic [SINE_TABLE_BITS-1:0] idx_raw;
    logic [IDX_W-1:0]           tbl_idx;
    logic signed [16:0]         tbl_mag;
    logic signed [16:0]         tbl_val;

    assign angle_sel = (state_reg == S_SPD) ? pose_heading_reg
                                            : pose_heading_reg + 16'h4000;
    assign idx_raw   = angle_sel[13 -: SINE_TABLE_BITS];
    assign tbl_idx   = angle_sel[14] ? IDX_W'(QUARTER) - {1'b0, idx_raw}
                                     : {1'b0, idx_raw};
    assign tbl_mag   = signed'({1'b0, sine_rom[tbl_idx]});
    assign tbl_val   = angle_sel[15] ? -tbl_mag : tbl_mag;

    // shared multiplier operand select
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_prod;

    always_comb begin
        case (state_reg)
            S_SPD: begin
                mul_a = 32'(speed_reg);
                mul_b = signed'({1'b0, step_time_reg});
            end
            S_RATE: begin
                mul_a = 32'(rate_reg);
                mul_b = signed'({1'b0, step_time_reg});
            end
            S_HEAD: begin
                mul_a = pv_reg;
                mul_b = sin_reg;
            end
            default: begin
                mul_a = pv_reg;
                mul_b = cos_reg;
            end
        endcase
    end

    assign mul_prod = 49'(mul_a) * 49'(mul_b);

    // rounding of the Q.39 position delta to Q16.16
    logic signed [48:0] rnd_sum;
    assign rnd_sum = prod_reg + 49'sd4194304;

    // heading delta rounded to angle units, low 16 bits only
    logic [31:0] head_sum;
    assign head_sum = prod_reg[31:0] + 32'h0000_8000;

    // saturating position add
    logic signed [31:0] add_pos;
    logic signed [32:0] add_sum;
    logic signed [31:0] add_res;
    logic               add_ovf;

    assign add_pos = (state_reg == S_ADDX) ? pose_x_reg : pose_y_reg;
    assign add_sum = 33'(add_pos) + 33'(delta_reg);
    assign add_ovf = add_sum[32] != add_sum[31];

    always_comb begin
        if (!add_ovf) begin
            add_res = add_sum[31:0];
        end else if (add_sum[32]) begin
            add_res = 32'sh8000_0000;
        end else begin
            add_res = 32'sh7fff_ffff;
        end
    end

    // sequencer and next values
    always_comb begin
        state_next        = state_reg;
        step_time_next    = step_time_reg;
        pose_x_next       = pose_x_reg;
        pose_y_next       = pose_y_reg;
        pose_heading_next = pose_heading_reg;
        m_tvalid_next     = m_tvalid_reg;
        speed_next        = speed_reg;
        rate_next         = rate_reg;
        prod_next         = prod_reg;
        pv_next           = pv_reg;
        sin_next          = sin_reg;
        cos_next          = cos_reg;
        delta_next        = delta_reg;
        clip_next         = clip_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        if (cfg_valid) begin
            step_time_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    speed_next = signed'(s_tdata[15:0]);
                    rate_next  = signed'(s_tdata[39:16]);
                    state_next = S_SPD;
                end
            end
            S_SPD: begin
                prod_next  = mul_prod;
                sin_next   = tbl_val;
                state_next = S_RATE;
            end
            S_RATE: begin
                pv_next    = prod_reg[31:0];
                prod_next  = mul_prod;
                cos_next   = tbl_val;
                state_next = S_HEAD;
            end
            S_HEAD: begin
                pose_heading_next = pose_heading_reg + head_sum[31:16];
                prod_next         = mul_prod;
                state_next        = S_RNDX;
            end
            S_RNDX: begin
                delta_next = rnd_sum[48:23];
                prod_next  = mul_prod;
                state_next = S_ADDX;
            end
            S_ADDX: begin
                pose_x_next = add_res;
                clip_next   = add_ovf;
                state_next  = S_RNDY;
            end
            S_RNDY: begin
                delta_next = rnd_sum[48:23];
                state_next = S_ADDY;
            end
            S_ADDY: begin
                pose_y_next = add_res;
                clip_next   = clip_reg | add_ovf;
                state_next  = S_OUT;
            end
            S_OUT: begin
                // wait until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {pose_heading_reg, pose_y_reg, pose_x_reg};
                    m_tuser_next  = clip_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and pose registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            step_time_reg    <= unicyc_pkg::STEP_TIME_RESET;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            step_time_reg    <= step_time_next;
            pose_x_reg       <= pose_x_next;
            pose_y_reg       <= pose_y_next;
            pose_heading_reg <= pose_heading_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        speed_reg   <= speed_next;
        rate_reg    <= rate_next;
        prod_reg    <= prod_next;
        pv_reg      <= pv_next;
        sin_reg     <= sin_next;
        cos_reg     <= cos_next;
        delta_reg   <= delta_next;
        clip_reg    <= clip_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // an accepted request always starts the multiply sequence
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_SPD))
        else $error("accepted request did not start the sequence");

    // a new result appears only from the output state
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

    // a new result carries the current stored heading
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[79:64] == pose_heading_reg))
        else $error("result heading differs from stored heading");

    // the saturation flag implies a position at a range limit
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
             m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000))
        else $error("saturation flag without a clipped position");
`endif

endmodule
